### sv/pslsu_pkg.sv
// Shared types, codes and constants of the periodic send/listen scheduler.
package pslsu_pkg;

  localparam int unsigned ListenDepth = 16;
  localparam int unsigned IdxW        = $clog2(ListenDepth);
  localparam int unsigned CntW        = 5;
  localparam int unsigned CmdDepth    = 2;
  localparam int unsigned RspDepth    = 2;
  localparam logic [15:0] TimeMax     = 16'hFFFF;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpStart = 2'd1,
    OpAdd   = 2'd2,
    OpDel   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PhaseStopped    = 2'd0,
    PhaseAfterSend  = 2'd1,
    PhaseAfterCheck = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CfgSendMessage  = 2'd0,
    CfgSendPeriod   = 2'd1,
    CfgPostSendWait = 2'd2,
    CfgCheckInterval = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] msg_value;
    logic        rx_pending;
    logic [31:0] rx_msg;
  } req_t;

  typedef struct packed {
    logic        send_now;
    logic [31:0] send_data;
    logic        checked;
    logic        matched;
    logic [31:0] last_matched;
    logic [1:0]  phase;
    logic [4:0]  listen_count;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic        key_vld;
  } cmd_t;

  function automatic logic [15:0] bump(input logic [15:0] c);
    return (c == TimeMax) ? c : c + 16'd1;
  endfunction

endpackage

### sv/periodic_send_listen_scheduler_unit.sv
// Top level of the periodic send/listen scheduler.
//
// Request words enter through push/full: a word is taken when push is high
// and full is low. Each word is a tick, a start, or an add or delete of a
// listened-for code. Every word yields exactly one result word, offered on
// rsp_o while empty is low and taken when pop is high.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once
// (send message, send period, post-send wait, check interval).
// A word with no table lookup passes the command queue, the back end and
// its result register on its way to rsp_o; a lookup scans the listen table
// one entry per cycle through its single read port, and a delete that moves
// an entry adds a read step and a write step. The back end handles one word
// at a time and takes no new word while its last result is still registered.
// Reset clears counters, phase, listen count and last match and restores
// the register defaults. When pop is held low the result queue fills, the
// back end holds and the request queue then raises full.
module periodic_send_listen_scheduler_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  pslsu_pkg::req_t req_i,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output pslsu_pkg::rsp_t rsp_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);

  pslsu_pkg::cmd_t                    cmd;
  logic                               cmd_empty, cmd_pop;
  pslsu_pkg::rsp_t                    rsp_int;
  logic                               rsp_push, rsp_full;
  logic [$bits(pslsu_pkg::rsp_t)-1:0] rsp_vec;

  pslsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .req_i       (req_i),
    .full        (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  pslsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_int)
  );

  pslsu_fifo #(
    .Width ($bits(pslsu_pkg::rsp_t)),
    .Depth (pslsu_pkg::RspDepth)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_int),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rsp_vec)
  );

  assign rsp_o = pslsu_pkg::rsp_t'(rsp_vec);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (rsp_o.listen_count <= pslsu_pkg::CntW'(pslsu_pkg::ListenDepth)))
    else $error("listen count above table depth");

  a_match_needs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.matched) |-> rsp_o.checked)
    else $error("match reported without a check");

  a_send_xor_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(rsp_o.send_now && rsp_o.checked))
    else $error("send and check in the same word");

  a_send_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.send_now) |-> (rsp_o.phase == pslsu_pkg::PhaseAfterSend))
    else $error("send without entering the after-send phase");

endmodule

### sv/pslsu_fifo.sv
// Small first-in first-out buffer for words of a given width.
module pslsu_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/pslsu_front.sv
// Front end: accepts request words, classifies them and queues commands.
module pslsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  pslsu_pkg::req_t    req_i,
  output logic               full,
  input  logic               cmd_pop_i,
  output logic               cmd_empty_o,
  output pslsu_pkg::cmd_t    cmd_o
);

  pslsu_pkg::cmd_t                    cmd;
  logic [$bits(pslsu_pkg::cmd_t)-1:0] cmd_vec;

  always_comb begin
    cmd.op      = pslsu_pkg::op_e'(req_i.req_type);
    cmd.key     = req_i.msg_value;
    cmd.key_vld = 1'b0;
    unique case (pslsu_pkg::op_e'(req_i.req_type))
      pslsu_pkg::OpTick: begin
        cmd.key     = req_i.rx_msg;
        cmd.key_vld = req_i.rx_pending;
      end
      pslsu_pkg::OpStart: begin
        cmd.key_vld = 1'b0;
      end
      pslsu_pkg::OpAdd, pslsu_pkg::OpDel: begin
        cmd.key_vld = 1'b1;
      end
      default: begin
        cmd.key_vld = 1'b0;
      end
    endcase
  end

  pslsu_fifo #(
    .Width ($bits(pslsu_pkg::cmd_t)),
    .Depth (pslsu_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty_o),
    .data_o  (cmd_vec)
  );

  assign cmd_o = pslsu_pkg::cmd_t'(cmd_vec);

endmodule

### sv/pslsu_back.sv
// Back end: timing counters, listen table and result generation.
module pslsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            cmd_empty_i,
  input  pslsu_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  logic            rsp_full_i,
  output logic            rsp_push_o,
  output pslsu_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = pslsu_pkg::IdxW;
  localparam int unsigned CntW = pslsu_pkg::CntW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StMoveRd,
    StMoveWr
  } state_e;

  state_e            state_q, state_d;
  logic [31:0]       send_message_q;
  logic [15:0]       send_period_q, post_send_wait_q, check_interval_q;
  logic [15:0]       since_send_q, since_send_d, since_check_q, since_check_d;
  pslsu_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [31:0]       last_hit_q, last_hit_d;
  pslsu_pkg::op_e    op_q, op_d;
  logic [31:0]       key_q, key_d;
  logic              do_send_q, do_send_d, do_check_q, do_check_d;
  logic [IdxW-1:0]   idx_q, idx_d, cmp_idx_q, cmp_idx_d, where_q, where_d;
  logic              issue_done_q, issue_done_d, cmp_vld_q, cmp_vld_d;
  pslsu_pkg::rsp_t   rsp_q, rsp_d;
  logic              rsp_vld_q, rsp_vld_d;

  logic [31:0]       mem [pslsu_pkg::ListenDepth];
  logic [31:0]       rd_data_q;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  logic [31:0]       wr_data;
  logic              wr_en;

  logic [15:0]       ss, sc;
  logic [CntW-1:0]   last_pos;
  logic              fin, hit, found, at_end;

  assign last_pos = used_q - CntW'(1);
  assign found    = cmp_vld_q && (rd_data_q == key_q);
  assign at_end   = cmp_vld_q && ({1'b0, cmp_idx_q} == last_pos);

  always_comb begin
    state_d      = state_q;
    since_send_d = since_send_q;
    since_check_d = since_check_q;
    phase_d      = phase_q;
    used_d       = used_q;
    last_hit_d   = last_hit_q;
    op_d         = op_q;
    key_d        = key_q;
    do_send_d    = do_send_q;
    do_check_d   = do_check_q;
    idx_d        = idx_q;
    cmp_idx_d    = cmp_idx_q;
    where_d      = where_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = 1'b0;
    rsp_d        = rsp_q;
    rsp_vld_d    = 1'b0;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = where_q;
    wr_data      = key_q;
    cmd_pop_o    = 1'b0;
    fin          = 1'b0;
    hit          = 1'b0;
    ss           = pslsu_pkg::bump(since_send_q);
    sc           = pslsu_pkg::bump(since_check_q);

    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i && !rsp_vld_q && !rsp_full_i) begin
          cmd_pop_o    = 1'b1;
          op_d         = cmd_i.op;
          key_d        = cmd_i.key;
          do_send_d    = 1'b0;
          do_check_d   = 1'b0;
          idx_d        = '0;
          issue_done_d = 1'b0;
          unique case (cmd_i.op)
            pslsu_pkg::OpTick: begin
              since_send_d  = ss;
              since_check_d = sc;
              if (phase_q == pslsu_pkg::PhaseAfterSend) begin
                do_check_d = (ss >= post_send_wait_q);
              end else if (phase_q == pslsu_pkg::PhaseAfterCheck) begin
                if (ss >= send_period_q) begin
                  do_send_d = 1'b1;
                end else begin
                  do_check_d = (sc >= check_interval_q);
                end
              end
              if (do_send_d) begin
                since_send_d = '0;
                phase_d      = pslsu_pkg::PhaseAfterSend;
              end
              if (do_check_d) begin
                since_check_d = '0;
                phase_d       = pslsu_pkg::PhaseAfterCheck;
              end
              if (do_check_d && cmd_i.key_vld && (used_q != '0)) begin
                state_d = StScan;
              end else begin
                fin = 1'b1;
              end
            end
            pslsu_pkg::OpStart: begin
              used_d        = '0;
              since_send_d  = '0;
              since_check_d = '0;
              phase_d       = pslsu_pkg::PhaseAfterSend;
              do_send_d     = 1'b1;
              fin           = 1'b1;
            end
            pslsu_pkg::OpAdd: begin
              if (used_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = cmd_i.key;
                used_d  = CntW'(1);
                fin     = 1'b1;
              end else if (used_q == CntW'(pslsu_pkg::ListenDepth)) begin
                fin = 1'b1;
              end else begin
                state_d = StScan;
              end
            end
            pslsu_pkg::OpDel: begin
              if (used_q == '0) begin
                fin = 1'b1;
              end else begin
                state_d = StScan;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      StScan: begin
        if (!issue_done_q) begin
          rd_addr      = idx_q;
          cmp_vld_d    = 1'b1;
          cmp_idx_d    = idx_q;
          idx_d        = idx_q + IdxW'(1);
          issue_done_d = ({1'b0, idx_q} == last_pos);
        end
        if (found || at_end) begin
          cmp_vld_d = 1'b0;
          case (op_q)
            pslsu_pkg::OpTick: begin
              hit = found;
              if (found) begin
                last_hit_d = key_q;
              end
              fin = 1'b1;
            end
            pslsu_pkg::OpAdd: begin
              if (!found) begin
                wr_en   = 1'b1;
                wr_addr = used_q[IdxW-1:0];
                wr_data = key_q;
                used_d  = used_q + CntW'(1);
              end
              fin = 1'b1;
            end
            pslsu_pkg::OpDel: begin
              if (found) begin
                where_d = cmp_idx_q;
                state_d = StMoveRd;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      StMoveRd: begin
        rd_addr = last_pos[IdxW-1:0];
        state_d = StMoveWr;
      end
      StMoveWr: begin
        wr_en   = 1'b1;
        wr_addr = where_q;
        wr_data = rd_data_q;
        used_d  = last_pos;
        fin     = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (fin) begin
      state_d              = StIdle;
      rsp_vld_d            = 1'b1;
      rsp_d.send_now       = do_send_d;
      rsp_d.send_data      = do_send_d ? send_message_q : '0;
      rsp_d.checked        = do_check_d;
      rsp_d.matched        = hit;
      rsp_d.last_matched   = last_hit_d;
      rsp_d.phase          = phase_d;
      rsp_d.listen_count   = used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      send_message_q   <= '0;
      send_period_q    <= 16'd1000;
      post_send_wait_q <= 16'd50;
      check_interval_q <= 16'd10;
      since_send_q     <= '0;
      since_check_q    <= '0;
      phase_q          <= pslsu_pkg::PhaseStopped;
      used_q           <= '0;
      last_hit_q       <= '0;
      op_q             <= pslsu_pkg::OpTick;
      do_send_q        <= 1'b0;
      do_check_q       <= 1'b0;
      idx_q            <= '0;
      cmp_idx_q        <= '0;
      where_q          <= '0;
      issue_done_q     <= 1'b0;
      cmp_vld_q        <= 1'b0;
      rsp_vld_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      since_send_q <= since_send_d;
      since_check_q <= since_check_d;
      phase_q      <= phase_d;
      used_q       <= used_d;
      last_hit_q   <= last_hit_d;
      op_q         <= op_d;
      do_send_q    <= do_send_d;
      do_check_q   <= do_check_d;
      idx_q        <= idx_d;
      cmp_idx_q    <= cmp_idx_d;
      where_q      <= where_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      rsp_vld_q    <= rsp_vld_d;
      if (cfg_we_i) begin
        unique case (pslsu_pkg::cfg_e'(cfg_idx_i))
          pslsu_pkg::CfgSendMessage:   send_message_q   <= cfg_data_i;
          pslsu_pkg::CfgSendPeriod:    send_period_q    <= cfg_data_i[15:0];
          pslsu_pkg::CfgPostSendWait:  post_send_wait_q <= cfg_data_i[15:0];
          pslsu_pkg::CfgCheckInterval: check_interval_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign rsp_push_o = rsp_vld_q;
  assign rsp_o      = rsp_q;

endmodule
